### design/mmla_pkg.sv
// ----------------------------------------------------------------------------
// mmla_pkg
// Shared types, constants and codes for the multi-mode loss accumulator.
// ----------------------------------------------------------------------------
package mmla_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int SUM_W        = 48;
    localparam int TERM_W       = 33;
    localparam int OPA_W        = 18;
    localparam int OPB_W        = 17;
    localparam int PROD_W       = OPA_W + OPB_W;
    localparam int DIV_STEPS    = SUM_W;
    localparam int STEP_W       = $clog2(DIV_STEPS);

    localparam logic [SUM_W-1:0] SUM_MAX      = {SUM_W{1'b1}};
    localparam logic [16:0]      GAMMA_ONE    = 17'h10000;
    localparam logic [16:0]      GAMMA_RESET  = 17'h08000;
    localparam logic [14:0]      THETA_RESET  = 15'd256;
    localparam logic signed [17:0] HINGE_MARGIN = 18'sd256;

    typedef enum logic [2:0] {
        MODE_SQUARED  = 3'd0,
        MODE_ABSOLUTE = 3'd1,
        MODE_HUBER    = 3'd2,
        MODE_QUANTILE = 3'd3,
        MODE_HINGE    = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        CFG_LOSS_MODE       = 2'd0,
        CFG_HUBER_THRESHOLD = 2'd1,
        CFG_QUANTILE_GAMMA  = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_FULL   = 2'd0,
        KIND_HALF   = 2'd1,
        KIND_Q8     = 2'd2,
        KIND_DIRECT = 2'd3
    } term_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_MUL  = 3'd1,
        ST_ACC  = 3'd2,
        ST_DIV  = 3'd3,
        ST_OUT  = 3'd4
    } state_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [14:0] threshold;
        logic [16:0] gamma;
    } loss_cfg_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [SUM_W-1:0] quotient;
    } div_rsp_t;

endpackage

### design/mmla_term.sv
// ----------------------------------------------------------------------------
// mmla_term
// Per-element loss term: operand selection, then one shared 18x17 multiply.
// ----------------------------------------------------------------------------
module mmla_term (
    input  logic                      clk,
    input  logic                      load,
    input  logic                      compute,
    input  logic signed [15:0]        target,
    input  logic signed [15:0]        predicted,
    input  mmla_pkg::loss_cfg_t       cfg,
    output logic [mmla_pkg::TERM_W-1:0] term,
    output logic                      hinge
);
    import mmla_pkg::*;

    logic signed [16:0]  diff;
    logic [16:0]         mag;
    logic [16:0]         gamma_sat;
    logic signed [17:0]  pred_ext;
    logic signed [17:0]  hinge_x;
    logic [TERM_W-1:0]   hinge_term;
    logic [OPA_W-1:0]    op_a;
    logic [OPB_W-1:0]    op_b;
    term_kind_t          kind;
    logic [TERM_W-1:0]   direct;
    logic [PROD_W-1:0]   product;

    logic [OPA_W-1:0]    op_a_reg;
    logic [OPB_W-1:0]    op_b_reg;
    term_kind_t          kind_reg;
    logic [TERM_W-1:0]   direct_reg;
    logic                hinge_reg;
    logic [TERM_W-1:0]   term_reg;
    logic [TERM_W-1:0]   term_next;

    always_comb
    begin
        diff      = {target[15], target} - {predicted[15], predicted};
        mag       = diff[16] ? 17'(~diff + 17'd1) : 17'(diff);
        gamma_sat = (cfg.gamma > GAMMA_ONE) ? GAMMA_ONE : cfg.gamma;
        pred_ext  = {{2{predicted[15]}}, predicted};

        // sign of target picks the margin direction
        if (!target[15] && (target != 16'sd0))
            hinge_x = HINGE_MARGIN - pred_ext;
        else if (target[15])
            hinge_x = HINGE_MARGIN + pred_ext;
        else
            hinge_x = HINGE_MARGIN;

        if (hinge_x[17] || (hinge_x == 18'sd0))
            hinge_term = '0;
        else
            hinge_term = TERM_W'({hinge_x[16:0], 8'b0});

        op_a   = {1'b0, mag};
        op_b   = mag;
        kind   = KIND_FULL;
        direct = '0;
        case (mode_t'(cfg.mode))
            MODE_ABSOLUTE:
            begin
                kind   = KIND_DIRECT;
                direct = TERM_W'({mag, 8'b0});
            end
            MODE_HUBER:
            begin
                kind = KIND_HALF;
                // linear region: theta * (2a - theta)
                if (mag > {2'b0, cfg.threshold})
                begin
                    op_a = OPA_W'({mag, 1'b0}) - OPA_W'(cfg.threshold);
                    op_b = {2'b0, cfg.threshold};
                end
            end
            MODE_QUANTILE:
            begin
                kind = KIND_Q8;
                op_a = diff[16] ? {1'b0, GAMMA_ONE - gamma_sat} : {1'b0, gamma_sat};
            end
            MODE_HINGE:
            begin
                kind   = KIND_DIRECT;
                direct = hinge_term;
            end
            default:
            begin
                kind = KIND_FULL;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_a_reg   <= op_a;
            op_b_reg   <= op_b;
            kind_reg   <= kind;
            direct_reg <= direct;
            hinge_reg  <= (mode_t'(cfg.mode) == MODE_HINGE);
        end
    end

    assign product = PROD_W'(op_a_reg) * PROD_W'(op_b_reg);

    always_comb
    begin
        case (kind_reg)
            KIND_FULL:   term_next = product[TERM_W-1:0];
            KIND_HALF:   term_next = product[TERM_W:1];
            KIND_Q8:     term_next = TERM_W'(product[PROD_W-1:8]);
            KIND_DIRECT: term_next = direct_reg;
            default:     term_next = product[TERM_W-1:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (compute)
            term_reg <= term_next;
    end

    assign term  = term_reg;
    assign hinge = hinge_reg;

endmodule

### design/mmla_div.sv
// ----------------------------------------------------------------------------
// mmla_div
// Restoring divider, one quotient bit per cycle: sum over element count.
// ----------------------------------------------------------------------------
module mmla_div (
    input  logic                clk,
    input  logic                rst_n,
    input  mmla_pkg::div_req_t  req,
    output mmla_pkg::div_rsp_t  rsp
);
    import mmla_pkg::*;

    logic               busy_reg;
    logic               done_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [SUM_W-1:0]   quot_reg;
    logic [CNT_W-1:0]   divisor_reg;

    logic [CNT_W:0]     shifted;
    logic               fits;
    logic [CNT_W-1:0]   rem_next;
    logic               last_step;

    always_comb
    begin
        shifted   = {rem_reg, quot_reg[SUM_W-1]};
        fits      = (shifted >= {1'b0, divisor_reg});
        rem_next  = fits ? CNT_W'(shifted - {1'b0, divisor_reg}) : shifted[CNT_W-1:0];
        last_step = (step_reg == STEP_W'(DIV_STEPS - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (last_step)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= '0;
            quot_reg    <= req.dividend;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[SUM_W-2:0], fits};
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule

### design/multi_mode_loss_accumulator.sv
// ----------------------------------------------------------------------------
// multi_mode_loss_accumulator
// Accumulates squared, absolute, huber, quantile or hinge loss over a vector
// of Q8.8 pairs and emits the mean (or the plain sum for hinge) on last.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       receive    in_valid / in_stall  target, predicted, last
//  out      send       out_valid / out_stall loss, saturated
//  cfg      receive    cfg_valid / cfg_ready cfg_index, cfg_data
//
//  an element without last passes through accept, then the shared multiply;
//  the sum update overlaps the next accept.
//  a last element passes through accept, the shared multiply and the sum
//  update, then for every mode but hinge the restoring divider (one quotient
//  bit per cycle, then done) before the output state; hinge skips the divider.
//  rst_n clears control, sum, count and the registers to their defaults.
//  a waiting result sits in the output register; a new vector may start
//  meanwhile, and the next result waits until that register is free.
// ----------------------------------------------------------------------------
module multi_mode_loss_accumulator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] target,
    input  logic signed [15:0] predicted,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [47:0]        loss,
    output logic               saturated,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [16:0]        cfg_data
);
    import mmla_pkg::*;

    state_t             state_reg;
    state_t             state_next;
    logic [2:0]         mode_reg;
    logic [14:0]        theta_reg;
    logic [16:0]        gamma_reg;
    loss_cfg_t          cfg;

    logic               accept;
    logic               last_reg;
    logic               acc_pend_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               ovf_reg;
    logic               sat_hold_reg;
    logic [SUM_W-1:0]   res_reg;
    logic               out_valid_reg;
    logic [SUM_W-1:0]   loss_reg;
    logic               saturated_reg;

    logic [TERM_W-1:0]  term;
    logic               hinge;
    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   sum_acc;
    logic               count_full;
    logic [CNT_W-1:0]   count_acc;
    logic               ovf_acc;
    logic               out_load;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    assign cfg_ready = 1'b1;
    assign cfg       = '{mode: mode_reg, threshold: theta_reg, gamma: gamma_reg};
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_SQUARED;
            theta_reg <= THETA_RESET;
            gamma_reg <= GAMMA_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_LOSS_MODE:       mode_reg  <= cfg_data[2:0];
                CFG_HUBER_THRESHOLD: theta_reg <= cfg_data[14:0];
                CFG_QUANTILE_GAMMA:  gamma_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    mmla_term u_term (
        .clk       (clk),
        .load      (accept),
        .compute   (state_reg == ST_MUL),
        .target    (target),
        .predicted (predicted),
        .cfg       (cfg),
        .term      (term),
        .hinge     (hinge)
    );

    mmla_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // saturating accumulate of the term produced in the cycle before
    always_comb
    begin
        sum_wide   = {1'b0, sum_reg} + (SUM_W + 1)'(term);
        sum_acc    = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
        count_full = (count_reg >= CNT_W'(MAX_ELEMENTS));
        count_acc  = count_full ? count_reg : count_reg + 1'b1;
        ovf_acc    = ovf_reg | sum_wide[SUM_W] | count_full;
    end

    always_comb
    begin
        state_next       = state_reg;
        div_req.start    = 1'b0;
        div_req.dividend = sum_acc;
        div_req.divisor  = count_acc;
        out_load         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = last_reg ? ST_ACC : ST_IDLE;
            end
            ST_ACC:
            begin
                if (hinge)
                    state_next = ST_OUT;
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_pend_reg  <= 1'b0;
            sum_reg       <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            acc_pend_reg <= (state_reg == ST_MUL);
            if (state_reg == ST_ACC)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else if (acc_pend_reg)
            begin
                sum_reg   <= sum_acc;
                count_reg <= count_acc;
                ovf_reg   <= ovf_acc;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            last_reg <= last;
        if (state_reg == ST_ACC)
        begin
            res_reg      <= sum_acc;
            sat_hold_reg <= ovf_acc;
        end
        else if ((state_reg == ST_DIV) && div_rsp.done)
            res_reg <= div_rsp.quotient;
        if (out_load)
        begin
            loss_reg      <= res_reg;
            saturated_reg <= sat_hold_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign loss      = loss_reg;
    assign saturated = saturated_reg;

`ifndef SYNTHESIS
    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("input taken while an element was still in work");

    a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.busy |-> (state_reg == ST_DIV))
        else $error("divider running outside the divide state");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ELEMENTS))
        else $error("element count beyond its limit");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_OUT))
        else $error("result shown without passing the output state");
`endif

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multi-mode loss accumulator. A predictor keeps
// its own copy of the registers, the running sum and the element count and
// computes the expected loss of every vector. Stimulus is a directed set of
// corner vectors, one over-long vector that clamps the element count, and
// random vectors under a series of register settings. The sender works
// in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module testbench;

    import mmla_pkg::*;

    localparam int SETTLE_CYCLES   = 64;
    localparam int CYCLE_LIMIT     = 1500000;
    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 66;
    localparam int HOLD_CYCLES     = 600;
    localparam int CLAMP_LENGTH    = MAX_ELEMENTS + 6;

    typedef struct {
        logic [SUM_W-1:0] loss;
        logic             saturated;
    } vector_loss_t;

    class loss_tracker;
        loss_cfg_t        regs;
        logic [SUM_W-1:0] running_sum;
        int               element_count;
        bit               clamped;
        vector_loss_t     expected_losses[$];
        int               errors;
        int               elements;
        int               vectors;
        int               checked;

        function new();
            regs.mode      = MODE_SQUARED;
            regs.threshold = THETA_RESET;
            regs.gamma     = GAMMA_RESET;
            running_sum    = '0;
            element_count  = 0;
            clamped        = 0;
            errors         = 0;
            elements       = 0;
            vectors        = 0;
            checked        = 0;
        endfunction

        function void write_register(cfg_index_t idx, logic [16:0] data);
            case (idx)
                CFG_LOSS_MODE:       regs.mode = data[2:0];
                CFG_HUBER_THRESHOLD: regs.threshold = data[14:0];
                CFG_QUANTILE_GAMMA:  regs.gamma = data;
                default:             ;
            endcase
        endfunction

        function logic [SUM_W-1:0] element_term(logic signed [15:0] t, logic signed [15:0] p);
            longint d;
            longint a;
            longint th;
            longint g;
            longint x;
            longint s;
            d  = longint'(t) - longint'(p);
            a  = (d < 0) ? -d : d;
            th = longint'(regs.threshold);
            g  = (regs.gamma > GAMMA_ONE) ? longint'(GAMMA_ONE) : longint'(regs.gamma);
            case (regs.mode)
                MODE_ABSOLUTE: return SUM_W'(a << 8);
                MODE_HUBER:
                begin
                    if (a <= th)
                        return SUM_W'((a * a) >> 1);
                    return SUM_W'((2 * th * a - th * th) >> 1);
                end
                MODE_QUANTILE:
                begin
                    if (t < p)
                        return SUM_W'(((65536 - g) * a) >> 8);
                    return SUM_W'((g * a) >> 8);
                end
                MODE_HINGE:
                begin
                    s = (t > 0) ? 1 : ((t < 0) ? -1 : 0);
                    x = 256 - s * longint'(p);
                    return (x > 0) ? SUM_W'(x << 8) : '0;
                end
                // unused codes fall back to squared error
                default: return SUM_W'(a * a);
            endcase
        endfunction

        function void note_element(logic signed [15:0] t, logic signed [15:0] p, logic l);
            logic [SUM_W-1:0] term;
            vector_loss_t     result;
            term = element_term(t, p);
            elements++;
            if (term > SUM_MAX - running_sum)
            begin
                running_sum = SUM_MAX;
                clamped     = 1;
            end
            else
                running_sum = running_sum + term;
            if (element_count >= MAX_ELEMENTS)
            begin
                element_count = MAX_ELEMENTS;
                clamped       = 1;
            end
            else
                element_count++;
            if (l)
            begin
                // hinge reports the plain sum, every other code the mean
                if (regs.mode == MODE_HINGE || element_count == 0)
                    result.loss = running_sum;
                else
                    result.loss = running_sum / SUM_W'(element_count);
                result.saturated = clamped;
                expected_losses.push_back(result);
                vectors++;
                running_sum   = '0;
                element_count = 0;
                clamped       = 0;
            end
        endfunction

        task report(string what, logic [SUM_W-1:0] got, logic [SUM_W-1:0] want);
            errors++;
            $display("mismatch in result %0d, %s: got 0x%0h, expected 0x%0h",
                     checked, what, got, want);
        endtask

        task check_loss(logic [SUM_W-1:0] got_loss, logic got_sat);
            vector_loss_t want;
            if (expected_losses.size() == 0)
                report("unexpected transaction", got_loss, '0);
            else
            begin
                want = expected_losses.pop_front();
                if (got_loss !== want.loss)
                    report("loss", got_loss, want.loss);
                if (got_sat !== want.saturated)
                    report("saturated", SUM_W'(got_sat), SUM_W'(want.saturated));
            end
            checked++;
        endtask

        function int pending();
            return expected_losses.size();
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [15:0] target = '0;
    logic signed [15:0] predicted = '0;
    logic               last = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [SUM_W-1:0]   loss;
    logic               saturated;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    cfg_index_t         cfg_index = CFG_LOSS_MODE;
    logic [16:0]        cfg_data = '0;

    loss_tracker tracker = new();
    bit          hold_request = 0;
    int          burst_left = 0;
    int          cycles = 0;

    logic signed [15:0] corner_values [8] = '{
        16'sh8000, 16'sh7fff, 16'sh0000, -16'sd1, 16'sd1, 16'sd256, -16'sd256, 16'sh7f00
    };

    multi_mode_loss_accumulator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .target    (target),
        .predicted (predicted),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .loss      (loss),
        .saturated (saturated),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    task automatic send_item(input logic signed [15:0] t, input logic signed [15:0] p,
                             input logic l);
        in_valid  <= 1'b1;
        target    <= t;
        predicted <= p;
        last      <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_element(t, p, l);
    endtask

    task automatic offer(input logic signed [15:0] t, input logic signed [15:0] p,
                         input logic l);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        send_item(t, p, l);
    endtask

    // wait until every vector result is out and any open element has drained
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [16:0] data);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.write_register(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_pair(output logic signed [15:0] t, output logic signed [15:0] p);
        case ($urandom_range(0, 6))
            0, 1:
            begin
                t = 16'($urandom);
                p = 16'($urandom);
            end
            2:
            begin
                t = 16'($urandom);
                p = t + 16'($urandom_range(0, 1023)) - 16'sd512;
            end
            3:
            begin
                t = corner_values[3'($urandom_range(0, 7))];
                p = corner_values[3'($urandom_range(0, 7))];
            end
            4:
            begin
                t = '0;
                p = 16'($urandom);
            end
            default:
            begin
                t = 16'($urandom_range(0, 4095)) - 16'sd2048;
                p = 16'($urandom_range(0, 4095)) - 16'sd2048;
            end
        endcase
    endtask

    initial
    begin : receiver
        int   seg_left;
        int   style;
        int   hold_left;
        logic stall_next;
        seg_left  = 0;
        style     = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                tracker.check_loss(loss, saturated);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 0;
            end
            if (seg_left == 0)
            begin
                style    = $urandom_range(0, 3);
                seg_left = $urandom_range(10, 150);
            end
            seg_left--;
            case (style)
                0:       stall_next = 1'b0;
                1:       stall_next = 1'($urandom_range(0, 1));
                2:       stall_next = seg_left[1];
                default: stall_next = ($urandom_range(0, 4) != 0);
            endcase
            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            out_stall <= stall_next;
        end
    end

    initial
    begin : watchdog
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("multi_mode_loss_accumulator test failed");
        $finish;
    end

    initial
    begin : stimulus
        logic signed [15:0] t;
        logic signed [15:0] p;
        logic [14:0]        theta;
        logic [16:0]        gamma;
        logic [2:0]         mode;
        int                 vec_left;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // reset settings: squared error first
        offer(16'sh7fff, 16'sh8000, 1'b1);
        offer(16'sh8000, 16'sh7fff, 1'b0);
        offer(16'sh0000, 16'sh0000, 1'b1);

        // huber and quantile at their reset threshold and gamma
        write_register(CFG_LOSS_MODE, 17'(MODE_HUBER));
        offer(16'sd100, 16'sd0, 1'b0);
        offer(16'sd0, 16'sd256, 1'b0);
        offer(16'sd0, 16'sd1000, 1'b1);
        write_register(CFG_LOSS_MODE, 17'(MODE_QUANTILE));
        offer(16'sd0, 16'sd100, 1'b0);
        offer(16'sd100, 16'sd0, 1'b1);

        // absolute error keeps the fraction of each element
        write_register(CFG_LOSS_MODE, 17'(MODE_ABSOLUTE));
        offer(16'sd1, 16'sd0, 1'b0);
        offer(16'sd0, 16'sd1, 1'b0);
        offer(16'sh8000, 16'sh7fff, 1'b1);

        // huber threshold extremes, upper data bits set on the wide write
        write_register(CFG_HUBER_THRESHOLD, 17'd0);
        write_register(CFG_LOSS_MODE, 17'(MODE_HUBER));
        offer(16'sd5, 16'sd5, 1'b0);
        offer(16'sh7fff, 16'sh8000, 1'b1);
        write_register(CFG_HUBER_THRESHOLD, 17'h1ffff);
        offer(16'sh7fff, 16'sh8000, 1'b1);

        // quantile gamma at zero and above one
        write_register(CFG_QUANTILE_GAMMA, 17'd0);
        write_register(CFG_LOSS_MODE, 17'(MODE_QUANTILE));
        offer(16'sd0, 16'sd100, 1'b0);
        offer(16'sd100, 16'sd0, 1'b1);
        write_register(CFG_QUANTILE_GAMMA, 17'h1ffff);
        offer(16'sd0, 16'sd100, 1'b0);
        offer(16'sd100, 16'sd0, 1'b1);

        // hinge: positive, negative and zero target signs
        write_register(CFG_LOSS_MODE, 17'(MODE_HINGE));
        offer(16'sd256, 16'sd0, 1'b0);
        offer(-16'sd256, 16'sh8000, 1'b0);
        offer(16'sd0, 16'sd500, 1'b0);
        offer(16'sh7fff, 16'sh7fff, 1'b0);
        offer(-16'sd1, 16'sh7fff, 1'b1);

        // unused mode codes behave as squared error
        write_register(CFG_LOSS_MODE, 17'd5);
        offer(16'sd3, -16'sd3, 1'b1);
        write_register(CFG_LOSS_MODE, 17'd7);
        offer(-16'sd3, 16'sd3, 1'b1);

        // mode change in the middle of an open vector
        write_register(CFG_LOSS_MODE, 17'(MODE_SQUARED));
        offer(16'sd10, 16'sd0, 1'b0);
        write_register(CFG_LOSS_MODE, 17'(MODE_HINGE));
        offer(16'sd0, 16'sd0, 1'b1);

        // element count clamps at the maximum without sum overflow
        write_register(CFG_LOSS_MODE, 17'(MODE_ABSOLUTE));
        for (int n = 0; n < CLAMP_LENGTH; n++)
        begin
            random_pair(t, p);
            offer(t, p, n == CLAMP_LENGTH - 1);
        end

        // random vectors; phases may cut a vector so settings change mid-vector
        vec_left = 0;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            mode = (ph < 8) ? 3'(ph) : 3'($urandom_range(0, 7));
            case ($urandom_range(0, 3))
                0:       theta = '0;
                1:       theta = 15'h7fff;
                2:       theta = 15'($urandom_range(0, 32767));
                default: theta = 15'($urandom_range(0, 2048));
            endcase
            case ($urandom_range(0, 4))
                0:       gamma = '0;
                1:       gamma = GAMMA_ONE;
                2:       gamma = 17'($urandom_range(65537, 131071));
                default: gamma = 17'($urandom_range(0, 65536));
            endcase
            write_register(CFG_HUBER_THRESHOLD, {2'($urandom), theta});
            write_register(CFG_QUANTILE_GAMMA, gamma);
            write_register(CFG_LOSS_MODE, {14'($urandom), mode});
            if (ph == 2)
                hold_request = 1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (vec_left == 0)
                    vec_left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 60)
                                                           : $urandom_range(1, 8);
                vec_left--;
                random_pair(t, p);
                offer(t, p, vec_left == 0);
            end
        end
        if (vec_left != 0)
        begin
            random_pair(t, p);
            offer(t, p, 1'b1);
        end

        settle();
        $display("covered %0d elements in %0d vectors, %0d results checked",
                 tracker.elements, tracker.vectors, tracker.checked);
        $display("all mode codes, register extremes and the count clamp exercised");
        if (tracker.errors == 0)
            $display("multi_mode_loss_accumulator test passed");
        else
            $display("multi_mode_loss_accumulator test failed");
        $finish;
    end

endmodule

### sim.f
design/mmla_pkg.sv
design/mmla_term.sv
design/mmla_div.sv
design/multi_mode_loss_accumulator.sv
bench/testbench.sv
